// ===== design/ctg_pkg.sv =====
// Shared types, constants and codes of the awareness send trigger.
package ctg_pkg;

  localparam int TIME_BITS           = 32;
  localparam int ANGLE_FRACTION_BITS = 60;
  localparam int FB                  = ANGLE_FRACTION_BITS;
  localparam int RAD_SHIFT           = 93 - FB;
  localparam int TRIG_TERMS          = 16;

  localparam logic [63:0]  FONE      = 64'd1 << FB;
  localparam logic [127:0] PI_126    = 128'hC90FDAA22168C234C4C6628B80DC1CD1;
  localparam logic [127:0] RAD_Q     = PI_126 / 128'd1800000000;
  localparam logic [63:0]  RAD_SCALE = RAD_Q[96:33];
  localparam logic [63:0]  ANG_THR   = (64'd2 << FB) / 64'd6378137;

  localparam logic [33:0] DEG360 = 34'd3600000000;
  localparam logic [33:0] DEG180 = 34'd1800000000;
  localparam logic [33:0] DEG90  = 34'd900000000;

  localparam logic [11:0] HEADING_MAX = 12'd3600;
  localparam logic [13:0] SPEED_NA    = 14'd16383;
  localparam logic [7:0]  COUNT_MAX   = 8'd255;

  localparam logic [15:0] RATE_MAX_RST   = 16'd1000;
  localparam logic [7:0]  RATE_COUNT_RST = 8'd3;
  localparam logic [11:0] HEADING_RST    = 12'd40;
  localparam logic [13:0] SPEED_RST      = 14'd50;
  localparam logic [15:0] LOW_FREQ_RST   = 16'd500;

  localparam logic [2:0] REG_STATION_ID_VALID = 3'd0;
  localparam logic [2:0] REG_RATE_MAX_MS      = 3'd1;
  localparam logic [2:0] REG_RATE_COUNT_MAX   = 3'd2;
  localparam logic [2:0] REG_HEADING_DELTA    = 3'd3;
  localparam logic [2:0] REG_SPEED_DELTA      = 3'd4;
  localparam logic [2:0] REG_LOW_FREQ_IVL     = 3'd5;

  typedef enum logic [2:0] {
    CAUSE_NONE, CAUSE_FIRST, CAUSE_HEADING, CAUSE_SPEED,
    CAUSE_POSITION, CAUSE_PERIODIC, CAUSE_NO_ID
  } ctg_cause_t;

  typedef enum logic [2:0] {
    JOB_DLAT, JOB_DLON, JOB_COS1, JOB_COS2, JOB_THR
  } ctg_job_t;

  typedef enum logic [3:0] {
    OP_NOP, OP_CAPTURE, OP_ANGLE, OP_MUL_START, OP_X_LOAD, OP_X2_LOAD,
    OP_DIV_START, OP_TERM_ACC, OP_TRIG_STORE, OP_H_LOAD, OP_T_LOAD,
    OP_H_ADD, OP_FAR, OP_COMMIT
  } ctg_op_t;

  typedef enum logic [2:0] {
    MS_RAD, MS_X2, MS_TERM, MS_C1C2, MS_TJ, MS_II, MS_SS
  } ctg_msel_t;

  typedef struct packed {
    logic        station_id_valid;
    logic [15:0] rate_max_ms;
    logic [7:0]  rate_count_max;
    logic [11:0] heading_delta;
    logic [13:0] speed_delta;
    logic [15:0] low_freq_interval_ms;
  } ctg_cfg_t;

  typedef struct packed {
    ctg_op_t   op;
    ctg_msel_t msel;
    ctg_job_t  job;
    logic      odd;
  } ctg_cmd_t;

  typedef struct packed {
    logic mul_done;
    logic div_done;
    logic need_pos;
  } ctg_status_t;

  typedef struct packed {
    logic       send;
    logic       low_freq;
    ctg_cause_t cause;
  } ctg_result_t;

endpackage

// ===== design/ctg_mul.sv =====
// Sequential 64 by 64 multiplier built from four 32 by 32 partial products.
module ctg_mul (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [63:0]   a,
  input  logic [63:0]   b,
  output logic          done,
  output logic [127:0]  prod
);

  logic [63:0]  a_r, b_r;
  logic [127:0] acc_r;
  logic [1:0]   step_r;
  logic         busy_r, done_r;
  logic [31:0]  a_part, b_part;
  logic [63:0]  pp;
  logic [127:0] pp_sh;

  always_comb begin
    a_part = step_r[1] ? a_r[63:32] : a_r[31:0];
    b_part = step_r[0] ? b_r[63:32] : b_r[31:0];
    pp     = a_part * b_part;
    case (step_r)
      2'd0:    pp_sh = {64'd0, pp};
      2'd3:    pp_sh = {pp, 64'd0};
      default: pp_sh = {32'd0, pp, 32'd0};
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= 2'd0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= 2'd0;
      end else if (busy_r) begin
        step_r <= step_r + 2'd1;
        if (step_r == 2'd3) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= a;
      b_r   <= b;
      acc_r <= 128'd0;
    end else if (busy_r) begin
      acc_r <= acc_r + pp_sh;
    end
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

// ===== design/ctg_div.sv =====
// Divider of a 64-bit word by one series denominator, by reciprocal multiplication.
module ctg_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [10:0] den,
  output logic        done,
  output logic [63:0] quo
);

  localparam int KMAX = 2 * ctg_pkg::TRIG_TERMS;

  typedef logic [KMAX-1:0][63:0] rcp_tab_t;

  function automatic rcp_tab_t make_tab();
    rcp_tab_t tab;
    for (int k = 1; k <= KMAX; k++) begin
      tab[k - 1] = 64'hFFFFFFFFFFFFFFFF / 64'(k * (k + 1));
    end
    return tab;
  endfunction

  localparam rcp_tab_t RCP_TAB = make_tab();

  // The reciprocal is at most one short, so the quotient needs at most one increment.
  function automatic logic [63:0] recip(input logic [10:0] d);
    logic [63:0] r;
    r = 64'd0;
    for (int k = 1; k <= KMAX; k++) begin
      if (d == 11'(k * (k + 1))) begin
        r = RCP_TAB[k - 1];
      end
    end
    return r;
  endfunction

  logic [63:0]  x_r, quo_r;
  logic [10:0]  den_r;
  logic         busy_r, done_r;
  logic [63:0]  rcp;
  logic         mul_done;
  logic [127:0] mul_prod;
  logic [63:0]  q0;
  logic [23:0]  qd;
  logic [11:0]  rem;
  logic         bump;

  assign rcp = recip(den);

  ctg_mul u_rmul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .a     (dividend),
    .b     (rcp),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  always_comb begin
    q0   = mul_prod[127:64];
    qd   = {12'd0, q0[11:0]} * {13'd0, den_r};
    rem  = x_r[11:0] - qd[11:0];
    bump = rem >= {1'b0, den_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && mul_done) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r   <= dividend;
      den_r <= den;
    end else if (busy_r && mul_done) begin
      quo_r <= q0 + {63'd0, bump};
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

// ===== design/ctg_datapath.sv =====
// Datapath: sample and history registers, trigger tests and the series engine.
module ctg_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ctg_pkg::ctg_cmd_t             cmd,
  input  ctg_pkg::ctg_cfg_t             cfg,
  input  logic [11:0]                   in_heading_tenths,
  input  logic [13:0]                   in_speed_cms,
  input  logic signed [30:0]            in_latitude,
  input  logic signed [31:0]            in_longitude,
  input  logic [ctg_pkg::TIME_BITS-1:0] in_now_ms,
  input  logic                          in_low_freq_present,
  output ctg_pkg::ctg_status_t          status,
  output ctg_pkg::ctg_result_t          result
);

  localparam int TB = ctg_pkg::TIME_BITS;
  localparam int FB = ctg_pkg::FB;

  logic [11:0]        hd_r;
  logic [13:0]        sp_r;
  logic [30:0]        lat_r;
  logic [31:0]        lon_r;
  logic [TB-1:0]      now_r;
  logic               lfp_r;
  logic               far_r;

  logic               have_prev_r;
  logic [11:0]        prev_heading_r;
  logic [13:0]        prev_speed_r;
  logic [31:0]        prev_lat_r, prev_lon_r;
  logic [TB-1:0]      last_send_r, last_lf_r;
  logic [15:0]        interval_r;
  logic [7:0]         icount_r;

  logic [30:0]        mag_r;
  logic [63:0]        x_r, x2_r, term_r, i_r, j_r, c1_r, c2_r, s_r, t_r;
  logic signed [63:0] sum_r;
  logic [5:0]         k_r;
  logic [127:0]       h_r;

  logic [63:0]        mul_a, mul_b;
  logic               mul_done, div_done;
  logic [127:0]       prod;
  logic [63:0]        quo;
  logic [63:0]        fmul_res;
  logic [10:0]        den;
  logic [12:0]        den_full;

  logic [31:0]        lat32;
  logic [30:0]        mag_nxt;
  logic [127:0]       rad_sh;
  logic [63:0]        x_nxt;
  logic               is_sin;
  logic [63:0]        trig_val;

  logic [11:0]        hd_diff, hd_mod;
  logic [13:0]        sp_diff;
  logic               heading_hit, speed_hit;
  logic [TB-1:0]      elapsed, lf_elapsed;
  logic               lf_keep;
  logic [7:0]         icount_inc;
  ctg_pkg::ctg_cause_t base_cause;

  function automatic logic [30:0] half_mag(input logic [31:0] a, input logic [31:0] b);
    logic [33:0] diff;
    logic [33:0] mag;
    logic [33:0] r1;
    logic [33:0] r2;
    logic [33:0] fold;
    diff = {{2{a[31]}}, a} - {{2{b[31]}}, b};
    mag  = diff[33] ? (34'd0 - diff) : diff;
    r1   = (mag >= ctg_pkg::DEG360) ? mag - ctg_pkg::DEG360 : mag;
    r2   = (r1 >= ctg_pkg::DEG360) ? r1 - ctg_pkg::DEG360 : r1;
    fold = (r2 > ctg_pkg::DEG180) ? ctg_pkg::DEG360 - r2 : r2;
    return fold[30:0];
  endfunction

  function automatic logic [30:0] lat_mag(input logic [31:0] v);
    logic [32:0] m;
    logic [33:0] mw;
    m  = v[31] ? (33'd0 - {v[31], v}) : {1'b0, v};
    mw = {1'b0, m};
    if (mw > ctg_pkg::DEG90) begin
      mw = ctg_pkg::DEG90;
    end
    return mw[30:0];
  endfunction

  ctg_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.op == ctg_pkg::OP_MUL_START),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (prod)
  );

  ctg_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.op == ctg_pkg::OP_DIV_START),
    .dividend (fmul_res),
    .den      (den),
    .done     (div_done),
    .quo      (quo)
  );

  always_comb begin
    case (cmd.msel)
      ctg_pkg::MS_RAD: begin
        mul_a = {33'd0, mag_r};
        mul_b = ctg_pkg::RAD_SCALE;
      end
      ctg_pkg::MS_X2: begin
        mul_a = x_r;
        mul_b = x_r;
      end
      ctg_pkg::MS_TERM: begin
        mul_a = term_r;
        mul_b = x2_r;
      end
      ctg_pkg::MS_C1C2: begin
        mul_a = c1_r;
        mul_b = c2_r;
      end
      ctg_pkg::MS_TJ: begin
        mul_a = t_r;
        mul_b = j_r;
      end
      ctg_pkg::MS_II: begin
        mul_a = i_r;
        mul_b = i_r;
      end
      ctg_pkg::MS_SS: begin
        mul_a = s_r;
        mul_b = s_r;
      end
      default: begin
        mul_a = 64'd0;
        mul_b = 64'd0;
      end
    endcase
  end

  always_comb begin
    fmul_res = prod[FB+63:FB];
    den_full = k_r * ({1'b0, k_r} + 7'd1);
    den      = den_full[10:0];
    lat32    = {lat_r[30], lat_r};
    is_sin   = (cmd.job == ctg_pkg::JOB_DLAT) || (cmd.job == ctg_pkg::JOB_DLON) ||
               (cmd.job == ctg_pkg::JOB_THR);
    case (cmd.job)
      ctg_pkg::JOB_DLAT: mag_nxt = half_mag(lat32, prev_lat_r);
      ctg_pkg::JOB_DLON: mag_nxt = half_mag(lon_r, prev_lon_r);
      ctg_pkg::JOB_COS1: mag_nxt = lat_mag(prev_lat_r);
      ctg_pkg::JOB_COS2: mag_nxt = lat_mag(lat32);
      default:           mag_nxt = 31'd0;
    endcase
    if (cmd.job == ctg_pkg::JOB_DLAT || cmd.job == ctg_pkg::JOB_DLON) begin
      rad_sh = prod >> (ctg_pkg::RAD_SHIFT + 1);
    end else begin
      rad_sh = prod >> ctg_pkg::RAD_SHIFT;
    end
    x_nxt    = (cmd.job == ctg_pkg::JOB_THR) ? ctg_pkg::ANG_THR : rad_sh[63:0];
    trig_val = sum_r[63] ? 64'd0 : sum_r;
  end

  always_comb begin
    hd_diff = (hd_r > prev_heading_r) ? hd_r - prev_heading_r : prev_heading_r - hd_r;
    hd_mod  = (hd_diff == ctg_pkg::HEADING_MAX) ? 12'd0 : hd_diff;
    heading_hit = (hd_r <= ctg_pkg::HEADING_MAX) && (prev_heading_r <= ctg_pkg::HEADING_MAX) &&
                  (hd_mod > cfg.heading_delta) &&
                  (({1'b0, hd_mod} + {1'b0, cfg.heading_delta}) < {1'b0, ctg_pkg::HEADING_MAX});
    sp_diff = (sp_r > prev_speed_r) ? sp_r - prev_speed_r : prev_speed_r - sp_r;
    speed_hit = (sp_r != ctg_pkg::SPEED_NA) && (prev_speed_r != ctg_pkg::SPEED_NA) &&
                (sp_diff > cfg.speed_delta);
    elapsed    = now_r - last_send_r;
    lf_elapsed = now_r - last_lf_r;
    lf_keep    = lfp_r && !(lf_elapsed < TB'(cfg.low_freq_interval_ms));
    icount_inc = (icount_r < ctg_pkg::COUNT_MAX) ? icount_r + 8'd1 : icount_r;

    if (!have_prev_r) begin
      base_cause = ctg_pkg::CAUSE_FIRST;
    end else if (heading_hit) begin
      base_cause = ctg_pkg::CAUSE_HEADING;
    end else if (speed_hit) begin
      base_cause = ctg_pkg::CAUSE_SPEED;
    end else if (far_r) begin
      base_cause = ctg_pkg::CAUSE_POSITION;
    end else begin
      base_cause = ctg_pkg::CAUSE_NONE;
    end

    if (!cfg.station_id_valid) begin
      result.send  = 1'b0;
      result.cause = ctg_pkg::CAUSE_NO_ID;
    end else if (base_cause != ctg_pkg::CAUSE_NONE) begin
      result.send  = 1'b1;
      result.cause = base_cause;
    end else if (elapsed >= TB'(interval_r)) begin
      result.send  = 1'b1;
      result.cause = ctg_pkg::CAUSE_PERIODIC;
    end else begin
      result.send  = 1'b0;
      result.cause = ctg_pkg::CAUSE_NONE;
    end
    result.low_freq = result.send && lf_keep;

    status.mul_done = mul_done;
    status.div_done = div_done;
    status.need_pos = cfg.station_id_valid && have_prev_r && !heading_hit && !speed_hit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      far_r          <= 1'b0;
      have_prev_r    <= 1'b0;
      prev_heading_r <= 12'd0;
      prev_speed_r   <= 14'd0;
      prev_lat_r     <= 32'd0;
      prev_lon_r     <= 32'd0;
      last_send_r    <= '0;
      last_lf_r      <= '0;
      interval_r     <= ctg_pkg::RATE_MAX_RST;
      icount_r       <= ctg_pkg::RATE_COUNT_RST;
    end else begin
      if (cmd.op == ctg_pkg::OP_CAPTURE) begin
        far_r <= 1'b0;
      end else if (cmd.op == ctg_pkg::OP_FAR) begin
        far_r <= h_r > prod;
      end
      if (cmd.op == ctg_pkg::OP_COMMIT && result.send) begin
        have_prev_r    <= 1'b1;
        prev_heading_r <= hd_r;
        prev_speed_r   <= sp_r;
        prev_lat_r     <= lat32;
        prev_lon_r     <= lon_r;
        last_send_r    <= now_r;
        if (result.low_freq) begin
          last_lf_r <= now_r;
        end
        if (result.cause == ctg_pkg::CAUSE_PERIODIC) begin
          icount_r <= icount_inc;
          if (icount_inc > cfg.rate_count_max) begin
            interval_r <= cfg.rate_max_ms;
          end
        end else begin
          icount_r   <= 8'd1;
          interval_r <= (elapsed < TB'(cfg.rate_max_ms)) ? elapsed[15:0] : cfg.rate_max_ms;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      ctg_pkg::OP_CAPTURE: begin
        hd_r  <= in_heading_tenths;
        sp_r  <= in_speed_cms;
        lat_r <= in_latitude;
        lon_r <= in_longitude;
        now_r <= in_now_ms;
        lfp_r <= in_low_freq_present;
      end
      ctg_pkg::OP_ANGLE:  mag_r <= mag_nxt;
      ctg_pkg::OP_X_LOAD: x_r   <= x_nxt;
      ctg_pkg::OP_X2_LOAD: begin
        x2_r   <= fmul_res;
        term_r <= is_sin ? x_r : ctg_pkg::FONE;
        sum_r  <= is_sin ? x_r : ctg_pkg::FONE;
        k_r    <= is_sin ? 6'd2 : 6'd1;
      end
      ctg_pkg::OP_TERM_ACC: begin
        term_r <= quo;
        sum_r  <= cmd.odd ? sum_r + quo : sum_r - quo;
        k_r    <= k_r + 6'd2;
      end
      ctg_pkg::OP_TRIG_STORE: begin
        case (cmd.job)
          ctg_pkg::JOB_DLAT: i_r  <= trig_val;
          ctg_pkg::JOB_DLON: j_r  <= trig_val;
          ctg_pkg::JOB_COS1: c1_r <= trig_val;
          ctg_pkg::JOB_COS2: c2_r <= trig_val;
          default:           s_r  <= trig_val;
        endcase
      end
      ctg_pkg::OP_H_LOAD: h_r <= prod;
      ctg_pkg::OP_H_ADD:  h_r <= h_r + prod;
      ctg_pkg::OP_T_LOAD: t_r <= fmul_res;
      default: begin
      end
    endcase
  end

endmodule

// ===== design/ctg_ctrl.sv =====
// Controller: sequences the trigger tests, the series evaluations and the final products.
module ctg_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 out_busy,
  input  ctg_pkg::ctg_status_t status,
  output logic                 in_stall,
  output ctg_pkg::ctg_cmd_t    cmd,
  output logic                 deliver
);

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_ANGLE, S_RADMUL, S_RADWAIT, S_XLOAD, S_X2MUL, S_X2WAIT,
    S_TMUL, S_TMWAIT, S_DIVWAIT, S_TSTORE, S_PMUL, S_PWAIT, S_FINISH
  } state_t;

  typedef enum logic [2:0] {
    P_II, P_C1C2, P_TJ, P_HB, P_THR
  } pstep_t;

  localparam logic [3:0] ITER_LAST = 4'(ctg_pkg::TRIG_TERMS - 1);

  state_t            state_r, state_nxt;
  ctg_pkg::ctg_job_t job_r, job_nxt;
  logic [3:0]        iter_r, iter_nxt;
  pstep_t            pstep_r, pstep_nxt;

  always_comb begin
    state_nxt = state_r;
    job_nxt   = job_r;
    iter_nxt  = iter_r;
    pstep_nxt = pstep_r;
    cmd.op    = ctg_pkg::OP_NOP;
    cmd.msel  = ctg_pkg::MS_RAD;
    cmd.job   = job_r;
    cmd.odd   = iter_r[0];
    deliver   = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = ctg_pkg::OP_CAPTURE;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (status.need_pos) begin
          job_nxt   = ctg_pkg::JOB_DLAT;
          state_nxt = S_ANGLE;
        end else begin
          state_nxt = S_FINISH;
        end
      end
      S_ANGLE: begin
        cmd.op    = ctg_pkg::OP_ANGLE;
        state_nxt = (job_r == ctg_pkg::JOB_THR) ? S_XLOAD : S_RADMUL;
      end
      S_RADMUL: begin
        cmd.op    = ctg_pkg::OP_MUL_START;
        state_nxt = S_RADWAIT;
      end
      S_RADWAIT: begin
        if (status.mul_done) begin
          state_nxt = S_XLOAD;
        end
      end
      S_XLOAD: begin
        cmd.op    = ctg_pkg::OP_X_LOAD;
        state_nxt = S_X2MUL;
      end
      S_X2MUL: begin
        cmd.op    = ctg_pkg::OP_MUL_START;
        cmd.msel  = ctg_pkg::MS_X2;
        state_nxt = S_X2WAIT;
      end
      S_X2WAIT: begin
        if (status.mul_done) begin
          cmd.op    = ctg_pkg::OP_X2_LOAD;
          iter_nxt  = 4'd0;
          state_nxt = S_TMUL;
        end
      end
      S_TMUL: begin
        cmd.op    = ctg_pkg::OP_MUL_START;
        cmd.msel  = ctg_pkg::MS_TERM;
        state_nxt = S_TMWAIT;
      end
      S_TMWAIT: begin
        if (status.mul_done) begin
          cmd.op    = ctg_pkg::OP_DIV_START;
          state_nxt = S_DIVWAIT;
        end
      end
      S_DIVWAIT: begin
        if (status.div_done) begin
          cmd.op = ctg_pkg::OP_TERM_ACC;
          if (iter_r == ITER_LAST) begin
            state_nxt = S_TSTORE;
          end else begin
            iter_nxt  = iter_r + 4'd1;
            state_nxt = S_TMUL;
          end
        end
      end
      S_TSTORE: begin
        cmd.op = ctg_pkg::OP_TRIG_STORE;
        if (job_r == ctg_pkg::JOB_THR) begin
          pstep_nxt = P_II;
          state_nxt = S_PMUL;
        end else begin
          job_nxt   = ctg_pkg::ctg_job_t'(job_r + 3'd1);
          state_nxt = S_ANGLE;
        end
      end
      S_PMUL: begin
        cmd.op = ctg_pkg::OP_MUL_START;
        case (pstep_r)
          P_II:    cmd.msel = ctg_pkg::MS_II;
          P_C1C2:  cmd.msel = ctg_pkg::MS_C1C2;
          P_THR:   cmd.msel = ctg_pkg::MS_SS;
          default: cmd.msel = ctg_pkg::MS_TJ;
        endcase
        state_nxt = S_PWAIT;
      end
      S_PWAIT: begin
        if (status.mul_done) begin
          case (pstep_r)
            P_II:    cmd.op = ctg_pkg::OP_H_LOAD;
            P_HB:    cmd.op = ctg_pkg::OP_H_ADD;
            P_THR:   cmd.op = ctg_pkg::OP_FAR;
            default: cmd.op = ctg_pkg::OP_T_LOAD;
          endcase
          if (pstep_r == P_THR) begin
            state_nxt = S_FINISH;
          end else begin
            pstep_nxt = pstep_t'(pstep_r + 3'd1);
            state_nxt = S_PMUL;
          end
        end
      end
      S_FINISH: begin
        if (!out_busy) begin
          cmd.op    = ctg_pkg::OP_COMMIT;
          deliver   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      job_r   <= ctg_pkg::JOB_DLAT;
      iter_r  <= 4'd0;
      pstep_r <= P_II;
    end else begin
      state_r <= state_nxt;
      job_r   <= job_nxt;
      iter_r  <= iter_nxt;
      pstep_r <= pstep_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

endmodule

// ===== design/cam_generation_trigger.sv =====
// Awareness send trigger: top level with register port, controller, datapath and result register.
// Each accepted word yields one result word telling whether the sample is sent, whether its
// low-frequency part is kept, and why. A sample decided without the position test passes from
// capture through the check and finish states to the result register. With a station identity
// set, a sample sent before and no heading or speed hit, the haversine position test evaluates
// five 17-term sine or cosine series; each of the sixteen terms after the first waits on the
// datapath multiplier and then on a reciprocal division. One sample is worked on at a time; the
// next one is accepted while a finished result still waits in the output register. Registers
// must be written only while no sample is in progress; the block itself does not enforce this.
module cam_generation_trigger (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [11:0]                   in_heading_tenths,
  input  logic [13:0]                   in_speed_cms,
  input  logic signed [30:0]            in_latitude,
  input  logic signed [31:0]            in_longitude,
  input  logic [ctg_pkg::TIME_BITS-1:0] in_now_ms,
  input  logic                          in_low_freq_present,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_send,
  output logic                          out_low_freq_included,
  output logic [2:0]                    out_cause,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [4:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  ctg_pkg::ctg_cfg_t    cfg_r;
  ctg_pkg::ctg_cmd_t    cmd;
  ctg_pkg::ctg_status_t status;
  ctg_pkg::ctg_result_t result;
  logic                 deliver, out_busy;
  logic                 out_valid_r, out_send_r, out_lf_r;
  logic [2:0]           out_cause_r;
  logic                 wr_en;
  logic [2:0]           reg_idx;

  assign pready   = 1'b1;
  assign wr_en    = psel && penable && pwrite;
  assign reg_idx  = paddr[4:2];
  assign out_busy = out_valid_r && out_stall;

  always_comb begin
    case (reg_idx)
      ctg_pkg::REG_STATION_ID_VALID: prdata = {31'd0, cfg_r.station_id_valid};
      ctg_pkg::REG_RATE_MAX_MS:      prdata = {16'd0, cfg_r.rate_max_ms};
      ctg_pkg::REG_RATE_COUNT_MAX:   prdata = {24'd0, cfg_r.rate_count_max};
      ctg_pkg::REG_HEADING_DELTA:    prdata = {20'd0, cfg_r.heading_delta};
      ctg_pkg::REG_SPEED_DELTA:      prdata = {18'd0, cfg_r.speed_delta};
      ctg_pkg::REG_LOW_FREQ_IVL:     prdata = {16'd0, cfg_r.low_freq_interval_ms};
      default:                       prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.station_id_valid     <= 1'b0;
      cfg_r.rate_max_ms          <= ctg_pkg::RATE_MAX_RST;
      cfg_r.rate_count_max       <= ctg_pkg::RATE_COUNT_RST;
      cfg_r.heading_delta        <= ctg_pkg::HEADING_RST;
      cfg_r.speed_delta          <= ctg_pkg::SPEED_RST;
      cfg_r.low_freq_interval_ms <= ctg_pkg::LOW_FREQ_RST;
    end else if (wr_en) begin
      case (reg_idx)
        ctg_pkg::REG_STATION_ID_VALID: cfg_r.station_id_valid     <= pwdata[0];
        ctg_pkg::REG_RATE_MAX_MS:      cfg_r.rate_max_ms          <= pwdata[15:0];
        ctg_pkg::REG_RATE_COUNT_MAX:   cfg_r.rate_count_max       <= pwdata[7:0];
        ctg_pkg::REG_HEADING_DELTA:    cfg_r.heading_delta        <= pwdata[11:0];
        ctg_pkg::REG_SPEED_DELTA:      cfg_r.speed_delta          <= pwdata[13:0];
        ctg_pkg::REG_LOW_FREQ_IVL:     cfg_r.low_freq_interval_ms <= pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  ctg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .out_busy (out_busy),
    .status   (status),
    .in_stall (in_stall),
    .cmd      (cmd),
    .deliver  (deliver)
  );

  ctg_datapath u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .cfg                 (cfg_r),
    .in_heading_tenths   (in_heading_tenths),
    .in_speed_cms        (in_speed_cms),
    .in_latitude         (in_latitude),
    .in_longitude        (in_longitude),
    .in_now_ms           (in_now_ms),
    .in_low_freq_present (in_low_freq_present),
    .status              (status),
    .result              (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (deliver) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (deliver) begin
      out_send_r  <= result.send;
      out_lf_r    <= result.low_freq;
      out_cause_r <= result.cause;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_send              = out_send_r;
  assign out_low_freq_included = out_lf_r;
  assign out_cause             = out_cause_r;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    deliver |-> !(out_valid_r && out_stall))
    else $error("Result word delivered while the previous one is still held.");

  a_deliver_shows: assert property (@(posedge clk) disable iff (!rst_n)
    deliver |=> out_valid_r)
    else $error("Delivered result word not presented.");

  a_lf_needs_send: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_lf_r) |-> out_send_r)
    else $error("Low-frequency part kept on a word that is not sent.");

  a_send_cause: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_send_r) |->
      (out_cause_r != ctg_pkg::CAUSE_NONE && out_cause_r != ctg_pkg::CAUSE_NO_ID))
    else $error("Sent word carries no valid send cause.");

endmodule

// ===== dv/tb_cam_generation_trigger.sv =====
// Self-checking testbench for the awareness send trigger, with its own bit-exact predictor.
`timescale 1ns / 100ps

module tb_cam_generation_trigger;

  localparam int IDLE_LIMIT = 40000;

  typedef struct {
    logic [11:0]        hd;
    logic [13:0]        sp;
    logic signed [30:0] lat;
    logic signed [31:0] lon;
    logic [31:0]        now;
    logic               lf;
  } sample_t;

  typedef struct {
    sample_t              s;
    bit                   typed;
    ctg_pkg::ctg_result_t res;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [11:0] in_heading_tenths = '0;
  logic [13:0] in_speed_cms = '0;
  logic signed [30:0] in_latitude = '0;
  logic signed [31:0] in_longitude = '0;
  logic [ctg_pkg::TIME_BITS-1:0] in_now_ms = '0;
  logic in_low_freq_present = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_send;
  logic out_low_freq_included;
  logic [2:0] out_cause;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  cam_generation_trigger dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Register copy and decision state of the predictor.
  ctg_pkg::ctg_cfg_t cfg;
  bit          seen;
  int unsigned last_hd, last_sp;
  longint      last_lat, last_lon;
  logic [31:0] sent_at, lf_sent_at;
  logic [15:0] ivl;
  logic [7:0]  ivl_count;

  ctg_pkg::ctg_result_t pending[$];
  int errors = 0;
  bit quiet = 1'b0;
  int stall_left = 0;
  int draw;
  int idle_cycles = 0;

  function automatic logic [63:0] fix_mul(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[123:60];
  endfunction

  function automatic logic [63:0] to_radians(logic [63:0] n, int extra);
    logic [127:0] q, p;
    q = 128'hC90FDAA22168C234C4C6628B80DC1CD1 / 128'd1800000000;
    p = {64'd0, n} * {64'd0, q[96:33]};
    p = p >> (33 + extra);
    return p[63:0];
  endfunction

  function automatic logic [63:0] series(logic [63:0] x, bit sine);
    logic [63:0] x2, term, k;
    longint sum;
    x2 = fix_mul(x, x);
    term = sine ? x : (64'd1 << 60);
    k = sine ? 64'd2 : 64'd1;
    sum = longint'(term);
    for (int it = 0; it < 16; it++) begin
      term = fix_mul(term, x2) / (k * (k + 64'd1));
      k += 64'd2;
      if (it & 1) sum += longint'(term);
      else sum -= longint'(term);
    end
    return (sum < 0) ? 64'd0 : 64'(sum);
  endfunction

  function automatic logic [63:0] half_delta(longint a, longint b);
    longint d;
    d = (a - b) % 64'sd3600000000;
    if (d > 64'sd1800000000) d -= 64'sd3600000000;
    if (d < -64'sd1800000000) d += 64'sd3600000000;
    return to_radians(d < 0 ? -d : d, 1);
  endfunction

  function automatic logic [63:0] cos_lat(longint lat);
    longint m;
    m = lat < 0 ? -lat : lat;
    if (m > 900000000) m = 900000000;
    return series(to_radians(m, 0), 1'b0);
  endfunction

  function automatic bit moved_far(longint lat1, longint lon1, longint lat2, longint lon2);
    logic [63:0] i, j, t, s;
    logic [127:0] h, th;
    i = series(half_delta(lat2, lat1), 1'b1);
    j = series(half_delta(lon2, lon1), 1'b1);
    t = fix_mul(fix_mul(cos_lat(lat1), cos_lat(lat2)), j);
    s = series((64'd2 << 60) / 64'd6378137, 1'b1);
    h = {64'd0, i} * {64'd0, i} + {64'd0, t} * {64'd0, j};
    th = {64'd0, s} * {64'd0, s};
    return h > th;
  endfunction

  function automatic ctg_pkg::ctg_result_t decide(sample_t s);
    ctg_pkg::ctg_result_t r;
    ctg_pkg::ctg_cause_t c;
    int unsigned d;
    logic [31:0] elapsed;
    bit keep_lf;
    r = '{send: 1'b0, low_freq: 1'b0, cause: ctg_pkg::CAUSE_NONE};
    c = ctg_pkg::CAUSE_NONE;
    elapsed = s.now - sent_at;
    if (!cfg.station_id_valid) begin
      r.cause = ctg_pkg::CAUSE_NO_ID;
      return r;
    end
    if (!seen) begin
      c = ctg_pkg::CAUSE_FIRST;
    end else begin
      if (s.hd <= 3600 && last_hd <= 3600) begin
        d = ((s.hd > last_hd) ? s.hd - last_hd : last_hd - s.hd) % 3600;
        if (d > cfg.heading_delta && d + cfg.heading_delta < 3600) c = ctg_pkg::CAUSE_HEADING;
      end
      if (c == ctg_pkg::CAUSE_NONE && s.sp != ctg_pkg::SPEED_NA &&
          last_sp != ctg_pkg::SPEED_NA) begin
        d = (s.sp > last_sp) ? s.sp - last_sp : last_sp - s.sp;
        if (d > cfg.speed_delta) c = ctg_pkg::CAUSE_SPEED;
      end
      if (c == ctg_pkg::CAUSE_NONE &&
          moved_far(last_lat, last_lon, longint'(s.lat), longint'(s.lon)))
        c = ctg_pkg::CAUSE_POSITION;
    end
    if (c != ctg_pkg::CAUSE_NONE) begin
      ivl = (elapsed < cfg.rate_max_ms) ? elapsed[15:0] : cfg.rate_max_ms;
      ivl_count = 8'd1;
    end else if (elapsed >= ivl) begin
      c = ctg_pkg::CAUSE_PERIODIC;
      if (ivl_count < ctg_pkg::COUNT_MAX) ivl_count++;
      if (ivl_count > cfg.rate_count_max) ivl = cfg.rate_max_ms;
    end else begin
      return r;
    end
    keep_lf = s.lf && !((s.now - lf_sent_at) < cfg.low_freq_interval_ms);
    seen = 1'b1;
    last_hd = s.hd;
    last_sp = s.sp;
    last_lat = longint'(s.lat);
    last_lon = longint'(s.lon);
    sent_at = s.now;
    if (keep_lf) lf_sent_at = s.now;
    r = '{send: 1'b1, low_freq: keep_lf, cause: c};
    return r;
  endfunction

  task automatic report(string what, int want, int got);
    $display("mismatch %s: expected %0d, got %0d at %0t", what, want, got, $realtime);
    errors++;
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      ctg_pkg::REG_STATION_ID_VALID: cfg.station_id_valid = value[0];
      ctg_pkg::REG_RATE_MAX_MS:      cfg.rate_max_ms = value[15:0];
      ctg_pkg::REG_RATE_COUNT_MAX:   cfg.rate_count_max = value[7:0];
      ctg_pkg::REG_HEADING_DELTA:    cfg.heading_delta = value[11:0];
      ctg_pkg::REG_SPEED_DELTA:      cfg.speed_delta = value[13:0];
      ctg_pkg::REG_LOW_FREQ_IVL:     cfg.low_freq_interval_ms = value[15:0];
      default: ;
    endcase
  endtask

  task automatic push_word(sample_t s, bit typed, ctg_pkg::ctg_result_t want);
    int gap;
    ctg_pkg::ctg_result_t r;
    gap = quiet ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_heading_tenths <= s.hd;
    in_speed_cms <= s.sp;
    in_latitude <= s.lat;
    in_longitude <= s.lon;
    in_now_ms <= s.now;
    in_low_freq_present <= s.lf;
    do @(posedge clk); while (in_stall);
    r = decide(s);
    pending.push_back(typed ? want : r);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  sample_t gen;

  function automatic sample_t next_sample();
    sample_t s;
    int pick;
    s = gen;
    pick = $urandom_range(0, 9);
    if (pick == 0) s.hd = 12'($urandom);
    else if (pick < 3) s.hd = 12'((gen.hd + $urandom_range(0, 120) + 3540) % 3600);
    pick = $urandom_range(0, 9);
    if (pick == 0) s.sp = 14'($urandom);
    else if (pick < 3) s.sp = 14'(gen.sp + $urandom_range(0, 160) - 80);
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      s.lat = 31'($urandom);
      s.lon = $urandom;
    end else if (pick < 7) begin
      s.lat = 31'(gen.lat + $signed($urandom_range(0, 1200)) - 600);
      s.lon = 32'(gen.lon + $signed($urandom_range(0, 1200)) - 600);
    end
    s.now = ($urandom_range(0, 40) == 0) ? $urandom : gen.now + $urandom_range(0, 1500);
    s.lf = 1'($urandom);
    gen = s;
    return s;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else begin
      draw = stall_left;
      if (out_valid && !out_stall) begin
        if (pending.size() == 0) begin
          report("unexpected word, cause", -1, out_cause);
        end else begin
          if (out_send !== pending[0].send) report("send", pending[0].send, out_send);
          if (out_low_freq_included !== pending[0].low_freq)
            report("low_freq_included", pending[0].low_freq, out_low_freq_included);
          if (out_cause !== pending[0].cause) report("cause", pending[0].cause, out_cause);
          void'(pending.pop_front());
        end
        draw = quiet ? 0 : $urandom_range(0, 14);
      end
      if (draw > 0) begin
        out_stall <= 1'b1;
        stall_left <= draw - 1;
      end else begin
        out_stall <= 1'b0;
        stall_left <= 0;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  row_t rows[$];

  function automatic sample_t mk(int hd, int sp, longint lat, longint lon, longint now, bit lf);
    sample_t s;
    s.hd = 12'(hd);
    s.sp = 14'(sp);
    s.lat = 31'(lat);
    s.lon = 32'(lon);
    s.now = 32'(now);
    s.lf = lf;
    return s;
  endfunction

  function automatic ctg_pkg::ctg_result_t res(bit send, bit lf, ctg_pkg::ctg_cause_t c);
    ctg_pkg::ctg_result_t r;
    r = '{send: send, low_freq: lf, cause: c};
    return r;
  endfunction

  initial begin
    ctg_pkg::ctg_result_t none;
    none = res(0, 0, ctg_pkg::CAUSE_NONE);
    cfg = '{station_id_valid: 1'b0, rate_max_ms: ctg_pkg::RATE_MAX_RST,
            rate_count_max: ctg_pkg::RATE_COUNT_RST,
            heading_delta: ctg_pkg::HEADING_RST, speed_delta: ctg_pkg::SPEED_RST,
            low_freq_interval_ms: ctg_pkg::LOW_FREQ_RST};
    seen = 0; last_hd = 0; last_sp = 0; last_lat = 0; last_lon = 0;
    sent_at = 0; lf_sent_at = 0; ivl = ctg_pkg::RATE_MAX_RST;
    ivl_count = ctg_pkg::RATE_COUNT_RST;
    gen = mk(0, 0, 0, 0, 0, 0);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Without a station identity nothing is sent.
    push_word(mk(4095, 16383, -1073741824, -2147483648, 32'hFFFFFFFF, 1), 1,
              res(0, 0, ctg_pkg::CAUSE_NO_ID));
    push_word(mk(0, 0, 1073741823, 2147483647, 0, 0), 1, res(0, 0, ctg_pkg::CAUSE_NO_ID));
    drain();
    write_reg(ctg_pkg::REG_STATION_ID_VALID, 1);
    write_reg(ctg_pkg::REG_RATE_MAX_MS, ctg_pkg::RATE_MAX_RST);
    write_reg(ctg_pkg::REG_RATE_COUNT_MAX, ctg_pkg::RATE_COUNT_RST);
    write_reg(ctg_pkg::REG_HEADING_DELTA, ctg_pkg::HEADING_RST);
    write_reg(ctg_pkg::REG_SPEED_DELTA, ctg_pkg::SPEED_RST);
    write_reg(ctg_pkg::REG_LOW_FREQ_IVL, ctg_pkg::LOW_FREQ_RST);

    rows.push_back('{mk(0, 100, 0, 0, 1000, 1), 1, res(1, 1, ctg_pkg::CAUSE_FIRST)});
    rows.push_back('{mk(3599, 100, 0, 0, 1100, 1), 0, none});
    rows.push_back('{mk(100, 100, 0, 0, 1200, 0), 1, res(1, 0, ctg_pkg::CAUSE_HEADING)});
    rows.push_back('{mk(3601, 100, 0, 0, 1300, 0), 0, none});
    rows.push_back('{mk(4095, 100, 0, 0, 1400, 1), 0, none});
    rows.push_back('{mk(4095, 16383, 0, 0, 1500, 0), 0, none});
    rows.push_back('{mk(4095, 0, 0, 0, 1600, 0), 0, none});
    rows.push_back('{mk(4095, 0, 400, 0, 1700, 1), 0, none});
    rows.push_back('{mk(4095, 0, 400, 400, 1800, 0), 0, none});
    rows.push_back('{mk(4095, 0, 900000001, 400, 1900, 0), 0, none});
    rows.push_back('{mk(4095, 0, -900000000, -1800000000, 2000, 0), 0, none});
    rows.push_back('{mk(4095, 0, -1073741824, 1800000001, 2100, 1), 0, none});
    rows.push_back('{mk(4095, 0, 1073741823, -2147483648, 2200, 0), 0, none});
    rows.push_back('{mk(4095, 0, 1073741823, 2147483647, 2300, 0), 0, none});
    rows.push_back('{mk(4095, 0, 1073741823, 2147483647, 4000, 1), 0, none});
    rows.push_back('{mk(4095, 0, 1073741823, 2147483647, 32'hFFFFFFFF, 1), 0, none});
    rows.push_back('{mk(4095, 0, 1073741823, 2147483647, 5, 1), 0, none});
    rows.push_back('{mk(4095, 0, 1073741823, 2147483647, 20, 0), 0, none});
    rows.push_back('{mk(0, 16383, 1073741823, 2147483647, 40, 1), 0, none});
    rows.push_back('{mk(3600, 0, 1073741823, 2147483647, 5000, 1), 0, none});
    foreach (rows[i]) push_word(rows[i].s, rows[i].typed, rows[i].res);
    gen = rows[rows.size() - 1].s;

    for (int p = 0; p < 7; p++) begin
      drain();
      quiet = (p == 3);
      case (p)
        1: begin
          write_reg(ctg_pkg::REG_RATE_MAX_MS, 1);
          write_reg(ctg_pkg::REG_RATE_COUNT_MAX, 1);
          write_reg(ctg_pkg::REG_HEADING_DELTA, 0);
          write_reg(ctg_pkg::REG_SPEED_DELTA, 0);
          write_reg(ctg_pkg::REG_LOW_FREQ_IVL, 0);
        end
        2: begin
          write_reg(ctg_pkg::REG_RATE_MAX_MS, 65535);
          write_reg(ctg_pkg::REG_RATE_COUNT_MAX, 255);
          write_reg(ctg_pkg::REG_HEADING_DELTA, 3600);
          write_reg(ctg_pkg::REG_SPEED_DELTA, 16383);
          write_reg(ctg_pkg::REG_LOW_FREQ_IVL, 65535);
        end
        4: write_reg(ctg_pkg::REG_STATION_ID_VALID, 0);
        5: write_reg(ctg_pkg::REG_STATION_ID_VALID, 1);
        default: begin
          write_reg(ctg_pkg::REG_RATE_MAX_MS, $urandom_range(1, 3000));
          write_reg(ctg_pkg::REG_RATE_COUNT_MAX, $urandom_range(1, 255));
          write_reg(ctg_pkg::REG_HEADING_DELTA, $urandom_range(0, 3600));
          write_reg(ctg_pkg::REG_SPEED_DELTA, $urandom_range(0, 16383));
          write_reg(ctg_pkg::REG_LOW_FREQ_IVL, $urandom);
        end
      endcase
      for (int n = 0; n < ((p == 4) ? 20 : 80); n++) begin
        if (p == 5 && n == 40) begin
          in_valid <= 1'b0;
          while (pending.size() != 0) @(posedge clk);
        end
        push_word(next_sample(), 0, none);
      end
    end

    in_valid <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0 && pending.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/ctg_pkg.sv
design/ctg_mul.sv
design/ctg_div.sv
design/ctg_datapath.sv
design/ctg_ctrl.sv
design/cam_generation_trigger.sv
dv/tb_cam_generation_trigger.sv
